@@ src/ifd_pkg.sv @@
`default_nettype none
package ifd_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 20;

   localparam int AXIS_W = 16;
   localparam int ABS_W = 16;
   localparam int PROD_W = 2 * ABS_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int MAG_W = SUM_W / 2;
   localparam int REM_W = MAG_W + 1;
   localparam int TIME_W = 32;
   localparam int LIMIT_W = 17;
   localparam int SPAN_W = 16;
   localparam int OFFS_W = 3 * AXIS_W;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 48;

   localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(113510);

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_OFFSETS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_OFFSETS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INSTABILITY_LIMIT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPACT_LIMIT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_VARIATION_LIMIT = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_ROTATION_LIMIT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_WINDOW_MS = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_CHECK_MS = 4'd7;

   localparam logic [LIMIT_W-1:0] INSTABILITY_RESET = 17'd9830;
   localparam logic [LIMIT_W-1:0] IMPACT_RESET = 17'd29491;
   localparam logic [LIMIT_W-1:0] STILL_VARIATION_RESET = 17'd9011;
   localparam logic [LIMIT_W-1:0] STILL_ROTATION_RESET = 17'd9170;
   localparam logic [SPAN_W-1:0] FALL_WINDOW_RESET = 16'd3000;
   localparam logic [SPAN_W-1:0] STILL_CHECK_RESET = 16'd2000;

   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_PREFALL = 2'd1;
   localparam logic [1:0] PH_IMPACT = 2'd2;
   localparam logic [1:0] PH_POSTFALL = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REARM = 1'b1;

   typedef struct packed {
      logic op;
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic signed [AXIS_W-1:0] rate_x;
      logic signed [AXIS_W-1:0] rate_y;
      logic signed [AXIS_W-1:0] rate_z;
      logic [TIME_W-1:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic fall_confirmed;
      logic [1:0] detector_state;
      logic [MAG_W-1:0] accel_magnitude;
      logic [MAG_W-1:0] window_variation;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic start;
      logic clear;
   } win_cmd_type;

   typedef struct packed {
      logic done;
      logic [MAG_W-1:0] variation;
   } win_sts_type;

endpackage
`default_nettype wire

@@ src/ifd_chan_if.sv @@
`default_nettype none
interface ifd_chan_if #(
   parameter type payload_type = logic
) ();
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/ifd_sqrt.sv @@
`default_nettype none
module ifd_sqrt
   import ifd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [SUM_W-1:0] operand,
   output logic done,
   output logic [MAG_W-1:0] root
);

   localparam int CNT_W = $clog2(MAG_W);

   logic running_ff, running_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] opnd_ff, opnd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] root_ff, root_in;
   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;

   always_comb begin
      running_in = running_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      opnd_in = opnd_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rem_sh = {rem_ff, opnd_ff[SUM_W-1 -: 2]};
      trial = {1'b0, root_ff, 2'b01};
      if (start) begin
         running_in = 1'b1;
         cnt_in = CNT_W'(MAG_W - 1);
         opnd_in = operand;
         rem_in = '0;
         root_in = '0;
      end else if (running_ff) begin
         opnd_in = {opnd_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = REM_W'(rem_sh - trial);
            root_in = {root_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[REM_W-1:0];
            root_in = {root_ff[MAG_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            running_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         running_ff <= running_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      opnd_ff <= opnd_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

@@ src/ifd_window.sv @@
`default_nettype none
module ifd_window
   import ifd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire win_cmd_type cmd,
   input  wire logic [MAG_W-1:0] wdata,
   output win_sts_type sts
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [1:0] {W_IDLE, W_FILL, W_SCAN, W_DONE} wstate_type;

   logic [MAG_W-1:0] mem [WINDOW_DEPTH];

   wstate_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic primed_ff, primed_in;
   logic rdv_ff, rdv_in;
   logic rdfirst_ff, rdfirst_in;
   logic [MAG_W-1:0] min_ff, min_in;
   logic [MAG_W-1:0] max_ff, max_in;
   logic [MAG_W-1:0] wdata_ff, wdata_in;
   logic [MAG_W-1:0] rdata_ff;
   logic we;
   logic [AW-1:0] waddr;
   logic [MAG_W-1:0] wval;
   logic rd_en;
   logic [AW-1:0] raddr;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      primed_in = primed_ff;
      rdv_in = 1'b0;
      rdfirst_in = rdfirst_ff;
      min_in = min_ff;
      max_in = max_ff;
      wdata_in = wdata_ff;
      we = 1'b0;
      waddr = slot_ff;
      wval = wdata;
      rd_en = 1'b0;
      raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         W_IDLE: begin
            if (cmd.clear) begin
               slot_in = '0;
               primed_in = 1'b0;
            end else if (cmd.start) begin
               wdata_in = wdata;
               idx_in = '0;
               if (!primed_ff) begin
                  state_in = W_FILL;
               end else begin
                  we = 1'b1;
                  slot_in = (slot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
                  state_in = W_SCAN;
               end
            end
         end
         W_FILL: begin
            we = 1'b1;
            waddr = idx_ff[AW-1:0];
            wval = wdata_ff;
            if (idx_ff == CW'(WINDOW_DEPTH - 1)) begin
               idx_in = '0;
               primed_in = 1'b1;
               slot_in = '0;
               state_in = W_SCAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         W_SCAN: begin
            if (idx_ff != CW'(WINDOW_DEPTH)) begin
               rd_en = 1'b1;
               rdv_in = 1'b1;
               rdfirst_in = (idx_ff == '0);
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = W_DONE;
            end
            if (rdv_ff) begin
               if (rdfirst_ff) begin
                  min_in = rdata_ff;
                  max_in = rdata_ff;
               end else begin
                  if (rdata_ff < min_ff) min_in = rdata_ff;
                  if (rdata_ff > max_ff) max_in = rdata_ff;
               end
            end
         end
         W_DONE: begin
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         idx_ff <= '0;
         slot_ff <= '0;
         primed_ff <= 1'b0;
         rdv_ff <= 1'b0;
         rdfirst_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         slot_ff <= slot_in;
         primed_ff <= primed_in;
         rdv_ff <= rdv_in;
         rdfirst_ff <= rdfirst_in;
      end
      min_ff <= min_in;
      max_ff <= max_in;
      wdata_ff <= wdata_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wval;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign sts.done = (state_ff == W_DONE);
   assign sts.variation = max_ff - min_ff;

endmodule
`default_nettype wire

@@ src/imu_fall_detector.sv @@
`default_nettype none
// Channel  Direction  Word                         Handshake
// req      in         op, six axes, time_ms        valid/ready, ready only when idle
// rsp      out        confirm, state, mag, var     valid/ready, output register
// csr      in         register index, data         valid/ready, always ready
//
// A sample word holds the block from its take to the earliest next take, for longer on
// the first sample after reset or rearm, when the window is filled, than otherwise; its
// result is delivered as the block returns to idle. Six multiply-accumulate steps, two
// 17-step square roots, each with its start, and the window fill and scan over its
// memory set this time. A rearm word clears the window and goes straight to delivery.
// Reset is synchronous and active high and clears the detector and the window.
// A new word is taken while a result waits; the block then stalls before delivery.
module imu_fall_detector
   import ifd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   ifd_chan_if.sink req_chan,
   ifd_chan_if.source rsp_chan,
   ifd_chan_if.sink csr_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ACC, S_ROOT_GO, S_ROOT_WAIT, S_WIN_GO, S_WIN_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   req_payload_type req_ff, req_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic sensor_ff, sensor_in;
   logic [1:0] axis_ff, axis_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [MAG_W-1:0] amag_ff, amag_in;
   logic [MAG_W-1:0] gmag_ff, gmag_in;
   logic [MAG_W-1:0] var_ff, var_in;
   logic [1:0] phase_ff, phase_in;
   logic [TIME_W-1:0] wst_ff, wst_in;
   logic [TIME_W-1:0] istamp_ff, istamp_in;

   logic [OFFS_W-1:0] accel_off_ff, gyro_off_ff;
   logic [LIMIT_W-1:0] inst_lim_ff, impact_lim_ff, svar_lim_ff, srot_lim_ff;
   logic [SPAN_W-1:0] fall_win_ff, still_chk_ff;

   logic [AXIS_W-1:0] raw_sel, off_sel;
   logic signed [AXIS_W:0] diff;
   logic [AXIS_W:0] diff_abs;
   logic [ABS_W-1:0] abs_val;
   logic [TIME_W-1:0] since_start, since_impact;
   logic confirmed;
   logic sqrt_start, sqrt_done;
   logic [MAG_W-1:0] sqrt_root;
   win_cmd_type win_cmd;
   win_sts_type win_sts;
   logic req_fire, deliver;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      case ({sensor_ff, axis_ff})
         3'd0: begin raw_sel = req_ff.accel_x; off_sel = accel_off_ff[15:0]; end
         3'd1: begin raw_sel = req_ff.accel_y; off_sel = accel_off_ff[31:16]; end
         3'd2: begin raw_sel = req_ff.accel_z; off_sel = accel_off_ff[47:32]; end
         3'd4: begin raw_sel = req_ff.rate_x; off_sel = gyro_off_ff[15:0]; end
         3'd5: begin raw_sel = req_ff.rate_y; off_sel = gyro_off_ff[31:16]; end
         default: begin raw_sel = req_ff.rate_z; off_sel = gyro_off_ff[47:32]; end
      endcase
      diff = $signed({raw_sel[AXIS_W-1], raw_sel}) - $signed({off_sel[AXIS_W-1], off_sel});
      diff_abs = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : diff;
      abs_val = diff_abs[ABS_W-1:0];
   end

   assign since_start = req_ff.time_ms - wst_ff;
   assign since_impact = req_ff.time_ms - istamp_ff;
   assign deliver = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sensor_in = sensor_ff;
      axis_in = axis_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      amag_in = amag_ff;
      gmag_in = gmag_ff;
      var_in = var_ff;
      phase_in = phase_ff;
      wst_in = wst_ff;
      istamp_in = istamp_ff;
      confirmed = 1'b0;
      sqrt_start = 1'b0;
      win_cmd.start = 1'b0;
      win_cmd.clear = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in = req_chan.payload;
               sensor_in = 1'b0;
               axis_in = '0;
               acc_in = '0;
               if (req_chan.payload.op == OP_REARM) begin
                  win_cmd.clear = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in = abs_val * abs_val;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + SUM_W'(prod_ff);
            if (axis_ff == 2'd2) begin
               axis_in = '0;
               state_in = S_ROOT_GO;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (sqrt_done) begin
               if (!sensor_ff) begin
                  amag_in = sqrt_root;
                  sensor_in = 1'b1;
                  acc_in = '0;
                  state_in = S_MUL;
               end else begin
                  gmag_in = sqrt_root;
                  state_in = S_WIN_GO;
               end
            end
         end
         S_WIN_GO: begin
            win_cmd.start = 1'b1;
            state_in = S_WIN_WAIT;
         end
         S_WIN_WAIT: begin
            if (win_sts.done) begin
               var_in = win_sts.variation;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (deliver) begin
               if (req_ff.op == OP_REARM) begin
                  phase_in = PH_NORMAL;
                  rsp_in = '0;
               end else begin
                  case (phase_ff)
                     PH_NORMAL: begin
                        if (var_ff > inst_lim_ff) begin
                           wst_in = req_ff.time_ms;
                           phase_in = PH_PREFALL;
                        end
                     end
                     PH_PREFALL: begin
                        if (amag_ff > impact_lim_ff) begin
                           istamp_in = req_ff.time_ms;
                           phase_in = PH_IMPACT;
                        end else if (since_start > TIME_W'(fall_win_ff)) begin
                           phase_in = PH_NORMAL;
                        end
                     end
                     PH_IMPACT: begin
                        if (since_impact > TIME_W'(still_chk_ff)) begin
                           if (var_ff < svar_lim_ff && gmag_ff < srot_lim_ff) begin
                              phase_in = PH_POSTFALL;
                              confirmed = 1'b1;
                           end else begin
                              phase_in = PH_NORMAL;
                           end
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
                  rsp_in.fall_confirmed = confirmed;
                  rsp_in.detector_state = phase_in;
                  rsp_in.accel_magnitude = amag_ff;
                  rsp_in.window_variation = var_ff;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sensor_ff <= 1'b0;
         axis_ff <= '0;
         phase_ff <= PH_NORMAL;
         wst_ff <= '0;
         istamp_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sensor_ff <= sensor_in;
         axis_ff <= axis_in;
         phase_ff <= phase_in;
         wst_ff <= wst_in;
         istamp_ff <= istamp_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      amag_ff <= amag_in;
      gmag_ff <= gmag_in;
      var_ff <= var_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_off_ff <= '0;
         gyro_off_ff <= '0;
         inst_lim_ff <= INSTABILITY_RESET;
         impact_lim_ff <= IMPACT_RESET;
         svar_lim_ff <= STILL_VARIATION_RESET;
         srot_lim_ff <= STILL_ROTATION_RESET;
         fall_win_ff <= FALL_WINDOW_RESET;
         still_chk_ff <= STILL_CHECK_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.payload.index)
            CSR_ACCEL_OFFSETS: accel_off_ff <= csr_chan.payload.data[OFFS_W-1:0];
            CSR_GYRO_OFFSETS: gyro_off_ff <= csr_chan.payload.data[OFFS_W-1:0];
            CSR_INSTABILITY_LIMIT: inst_lim_ff <= csr_chan.payload.data[LIMIT_W-1:0];
            CSR_IMPACT_LIMIT: impact_lim_ff <= csr_chan.payload.data[LIMIT_W-1:0];
            CSR_STILL_VARIATION_LIMIT: svar_lim_ff <= csr_chan.payload.data[LIMIT_W-1:0];
            CSR_STILL_ROTATION_LIMIT: srot_lim_ff <= csr_chan.payload.data[LIMIT_W-1:0];
            CSR_FALL_WINDOW_MS: fall_win_ff <= csr_chan.payload.data[SPAN_W-1:0];
            CSR_STILL_CHECK_MS: still_chk_ff <= csr_chan.payload.data[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ifd_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .start(sqrt_start),
      .operand(acc_ff),
      .done(sqrt_done),
      .root(sqrt_root)
   );

   ifd_window #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .cmd(win_cmd),
      .wdata(amag_ff),
      .sts(win_sts)
   );

endmodule
`default_nettype wire

@@ src/ifd_checker.sv @@
`default_nettype none
module ifd_checker
   import ifd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   // The block works on one word at a time, so it is never ready right after a take.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on two consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result dropped or changed");

   a_confirm_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fall_confirmed |->
         rsp_payload.detector_state == PH_POSTFALL)
      else $error("fall confirmed outside post-fall");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.accel_magnitude <= MAG_MAX &&
         rsp_payload.window_variation <= MAG_MAX)
      else $error("magnitude or variation out of range");

endmodule

bind imu_fall_detector ifd_checker u_ifd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
`default_nettype wire
